// File: hw/rtl/rrfp_pkg.sv
// ----------------------------------------------------------------------------
// rrfp_pkg: radar report frame parser package
// Shared widths, frame constants, queue operation and field record types.
// ----------------------------------------------------------------------------
package rrfp_pkg;

  // Largest payload length accepted; longer frames are rejected.
  localparam int unsigned MAX_PAYLOAD = 60;
  // Payload position counter, able to hold MAX_PAYLOAD itself.
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);
  // Position compare width: light position reaches 13 + 255 + 255 + 1.
  localparam int unsigned POS_W       = (CNT_W > 10) ? CNT_W : 10;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Frame marker bytes.
  localparam logic [7:0] HDR_0 = 8'hF4;
  localparam logic [7:0] HDR_1 = 8'hF3;
  localparam logic [7:0] HDR_2 = 8'hF2;
  localparam logic [7:0] HDR_3 = 8'hF1;
  localparam logic [7:0] FTR_0 = 8'hF8;
  localparam logic [7:0] FTR_1 = 8'hF7;
  localparam logic [7:0] FTR_2 = 8'hF6;
  localparam logic [7:0] FTR_3 = 8'hF5;

  localparam logic [7:0] TYPE_ENG   = 8'h01;
  localparam logic [7:0] TYPE_BASIC = 8'h02;
  localparam logic [7:0] OUT_ON     = 8'h01;

  // Fixed payload positions.
  localparam int unsigned POS_STATUS  = 2;
  localparam int unsigned POS_MD_LO   = 3;
  localparam int unsigned POS_MD_HI   = 4;
  localparam int unsigned POS_ME      = 5;
  localparam int unsigned POS_SD_LO   = 6;
  localparam int unsigned POS_SD_HI   = 7;
  localparam int unsigned POS_SE      = 8;
  localparam int unsigned POS_DD_LO   = 9;
  localparam int unsigned POS_DD_HI   = 10;
  localparam int unsigned POS_GATE0   = 11;
  localparam int unsigned POS_GATE1   = 12;
  localparam int unsigned POS_LIGHT0  = 13;

  // Frame tracker phase.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_FOOTER
  } phase_e;

  typedef enum logic [1:0] {
    RES_OK         = 2'd0,
    RES_FOOTER_ERR = 2'd1,
    RES_LENGTH_ERR = 2'd2
  } result_code_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_ACCEPT,
    OP_ERR_FOOTER,
    OP_ERR_LEN
  } op_kind_e;

  typedef enum logic [3:0] {
    FLD_STATUS,
    FLD_MD_LO,
    FLD_MD_HI,
    FLD_ME,
    FLD_SD_LO,
    FLD_SD_HI,
    FLD_SE,
    FLD_DD_LO,
    FLD_DD_HI,
    FLD_LIGHT,
    FLD_OUT
  } field_e;

  // One queued operation from the front to the back.
  typedef struct packed {
    op_kind_e   kind;
    field_e     field;
    logic [7:0] data;    // captured byte, or report type on accept
    logic       commit;  // accept: copy shadow into held values
  } op_t;

  // Report values, used for both the shadow and the held copy.
  typedef struct packed {
    logic [7:0]  status;
    logic [15:0] mdist;
    logic [7:0]  menergy;
    logic [15:0] sdist;
    logic [7:0]  senergy;
    logic [15:0] ddist;
    logic [7:0]  light;
    logic        out;
  } report_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = HDR_0;
      2'd1:    b = HDR_1;
      2'd2:    b = HDR_2;
      default: b = HDR_3;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ftr_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = FTR_0;
      2'd1:    b = FTR_1;
      2'd2:    b = FTR_2;
      default: b = FTR_3;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/radar_report_frame_parser.sv
// ----------------------------------------------------------------------------
// radar_report_frame_parser: radar report frame parser top level
// Byte-stream frame parser with shadowed field capture and commit on footer.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   in       | in_valid_i / in_stall_o  | rx_byte_i
//   out      | out_valid_o / out_stall_i| result_code_o .. out_active_o
//
// One byte per cycle is accepted while in_stall_o is low; the frame tracker
// decides everything for a byte in the cycle it is taken. A result goes
// via the op queue to the output register after the frame's last byte (last
// footer byte, first wrong footer byte, or an oversized second length byte).
// The two-entry op queue decouples tracker and back part: in_stall_o rises
// only when the queue is full, which needs a stalled output register.
// Reset (async, active low) restarts header hunting and clears held values.

module radar_report_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_code_o,
  output logic [7:0]  report_type_o,
  output logic [7:0]  target_status_o,
  output logic [15:0] move_dist_o,
  output logic [7:0]  move_energy_o,
  output logic [15:0] still_dist_o,
  output logic [7:0]  still_energy_o,
  output logic [15:0] detect_distance_o,
  output logic [7:0]  light_level_o,
  output logic        out_active_o
);

  logic              q_full;
  logic              push;
  rrfp_pkg::op_t     push_op;
  logic              pop;
  logic              head_valid;
  rrfp_pkg::op_t     head_op;
  rrfp_pkg::report_t report;

  // Front: header/length/footer tracking and payload position decode.
  rrfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  assign in_stall_o = q_full;

  // Op queue; bytes that change only tracker state are never queued.
  rrfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_op_i    (push_op),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_op_o    (head_op)
  );

  // Back: shadow capture, commit, and the result register.
  rrfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_op_i     (head_op),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_code_o (result_code_o),
    .report_type_o (report_type_o),
    .report_o      (report)
  );

  assign target_status_o   = report.status;
  assign move_dist_o       = report.mdist;
  assign move_energy_o     = report.menergy;
  assign still_dist_o      = report.sdist;
  assign still_energy_o    = report.senergy;
  assign detect_distance_o = report.ddist;
  assign light_level_o     = report.light;
  assign out_active_o      = report.out;

endmodule

// File: hw/rtl/rrfp_front.sv
// ----------------------------------------------------------------------------
// rrfp_front: frame tracker
// Hunts header, checks length and footer, maps payload bytes to field ops.
// ----------------------------------------------------------------------------
module rrfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output rrfp_pkg::op_t     push_op_o
);

  rrfp_pkg::phase_e           phase_q, phase_d;
  logic [1:0]                 match_q, match_d;
  logic [rrfp_pkg::CNT_W-1:0] count_q, count_d;
  logic [rrfp_pkg::CNT_W-1:0] length_q, length_d;
  logic [7:0]                 len_lo_q, len_lo_d;
  logic [7:0]                 type_q, type_d;
  logic [7:0]                 gate0_q, gate0_d;
  logic [7:0]                 gate1_q, gate1_d;

  logic                       accept;
  logic [15:0]                len_full;
  logic                       len_bad;
  logic [rrfp_pkg::CNT_W:0]   count_inc;
  logic [rrfp_pkg::POS_W-1:0] pos;
  logic [rrfp_pkg::POS_W-1:0] light_at;
  rrfp_pkg::op_t              op;

  assign accept    = in_valid_i && !q_full_i;
  assign len_full  = {rx_byte_i, len_lo_q};
  assign len_bad   = len_full > 16'(rrfp_pkg::MAX_PAYLOAD);
  assign count_inc = {1'b0, count_q} + 1'b1;
  assign pos       = rrfp_pkg::POS_W'(count_q);
  assign light_at  = rrfp_pkg::POS_W'(rrfp_pkg::POS_LIGHT0)
                   + rrfp_pkg::POS_W'(gate0_q) + rrfp_pkg::POS_W'(gate1_q);

  // Next state
  always_comb begin
    phase_d  = phase_q;
    match_d  = match_q;
    count_d  = count_q;
    length_d = length_q;
    len_lo_d = len_lo_q;
    type_d   = type_q;
    gate0_d  = gate0_q;
    gate1_d  = gate1_q;
    if (accept) begin
      unique case (phase_q)
        rrfp_pkg::PH_LEN_LO: begin
          len_lo_d = rx_byte_i;
          phase_d  = rrfp_pkg::PH_LEN_HI;
        end
        rrfp_pkg::PH_LEN_HI: begin
          match_d = 2'd0;
          if (len_bad) begin
            phase_d = rrfp_pkg::PH_HUNT;
          end else begin
            length_d = rrfp_pkg::CNT_W'(len_full);
            count_d  = '0;
            type_d   = '0;
            gate0_d  = '0;
            gate1_d  = '0;
            phase_d  = (len_full != 16'd0) ? rrfp_pkg::PH_PAYLOAD : rrfp_pkg::PH_FOOTER;
          end
        end
        rrfp_pkg::PH_PAYLOAD: begin
          if (pos == '0) begin
            type_d = rx_byte_i;
          end else if (type_q == rrfp_pkg::TYPE_ENG) begin
            if (pos == rrfp_pkg::POS_W'(rrfp_pkg::POS_GATE0)) begin
              gate0_d = rx_byte_i;
            end else if (pos == rrfp_pkg::POS_W'(rrfp_pkg::POS_GATE1)) begin
              gate1_d = rx_byte_i;
            end
          end
          count_d = count_inc[rrfp_pkg::CNT_W-1:0];
          if (count_inc >= {1'b0, length_q}) begin
            phase_d = rrfp_pkg::PH_FOOTER;
            match_d = 2'd0;
          end
        end
        rrfp_pkg::PH_FOOTER: begin
          if (rx_byte_i == rrfp_pkg::ftr_byte(match_q)) begin
            if (match_q == 2'd3) begin
              phase_d = rrfp_pkg::PH_HUNT;
              match_d = 2'd0;
            end else begin
              match_d = match_q + 2'd1;
            end
          end else begin
            phase_d = rrfp_pkg::PH_HUNT;
            match_d = (rx_byte_i == rrfp_pkg::HDR_0) ? 2'd1 : 2'd0;
          end
        end
        default: begin
          phase_d = rrfp_pkg::PH_HUNT;
          if (rx_byte_i == rrfp_pkg::hdr_byte(match_q)) begin
            if (match_q == 2'd3) begin
              match_d = 2'd0;
              phase_d = rrfp_pkg::PH_LEN_LO;
            end else begin
              match_d = match_q + 2'd1;
            end
          end else begin
            match_d = (rx_byte_i == rrfp_pkg::HDR_0) ? 2'd1 : 2'd0;
          end
        end
      endcase
    end
  end

  // Operation for the back part
  always_comb begin
    op.kind   = rrfp_pkg::OP_NONE;
    op.field  = rrfp_pkg::FLD_STATUS;
    op.data   = rx_byte_i;
    op.commit = 1'b0;
    unique case (phase_q)
      rrfp_pkg::PH_LEN_HI: begin
        op.kind = len_bad ? rrfp_pkg::OP_ERR_LEN : rrfp_pkg::OP_LOAD;
      end
      rrfp_pkg::PH_PAYLOAD: begin
        op.kind = rrfp_pkg::OP_CAPTURE;
        case (pos)
          rrfp_pkg::POS_W'(rrfp_pkg::POS_STATUS): op.field = rrfp_pkg::FLD_STATUS;
          rrfp_pkg::POS_W'(rrfp_pkg::POS_MD_LO):  op.field = rrfp_pkg::FLD_MD_LO;
          rrfp_pkg::POS_W'(rrfp_pkg::POS_MD_HI):  op.field = rrfp_pkg::FLD_MD_HI;
          rrfp_pkg::POS_W'(rrfp_pkg::POS_ME):     op.field = rrfp_pkg::FLD_ME;
          rrfp_pkg::POS_W'(rrfp_pkg::POS_SD_LO):  op.field = rrfp_pkg::FLD_SD_LO;
          rrfp_pkg::POS_W'(rrfp_pkg::POS_SD_HI):  op.field = rrfp_pkg::FLD_SD_HI;
          rrfp_pkg::POS_W'(rrfp_pkg::POS_SE):     op.field = rrfp_pkg::FLD_SE;
          rrfp_pkg::POS_W'(rrfp_pkg::POS_DD_LO):  op.field = rrfp_pkg::FLD_DD_LO;
          rrfp_pkg::POS_W'(rrfp_pkg::POS_DD_HI):  op.field = rrfp_pkg::FLD_DD_HI;
          default: begin
            // light_at is at least 13, so type, reserved and gate bytes never hit
            if (type_q == rrfp_pkg::TYPE_ENG && pos == light_at) begin
              op.field = rrfp_pkg::FLD_LIGHT;
            end else if (type_q == rrfp_pkg::TYPE_ENG && pos == light_at + 1'b1) begin
              op.field = rrfp_pkg::FLD_OUT;
            end else begin
              op.kind = rrfp_pkg::OP_NONE;
            end
          end
        endcase
      end
      rrfp_pkg::PH_FOOTER: begin
        if (rx_byte_i == rrfp_pkg::ftr_byte(match_q)) begin
          if (match_q == 2'd3) begin
            op.kind   = rrfp_pkg::OP_ACCEPT;
            op.data   = type_q;
            op.commit = (type_q == rrfp_pkg::TYPE_ENG) || (type_q == rrfp_pkg::TYPE_BASIC);
          end
        end else begin
          op.kind = rrfp_pkg::OP_ERR_FOOTER;
        end
      end
      default: begin
        op.kind = rrfp_pkg::OP_NONE;
      end
    endcase
  end

  assign push_o    = accept && (op.kind != rrfp_pkg::OP_NONE);
  assign push_op_o = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rrfp_pkg::PH_HUNT;
      match_q  <= '0;
      count_q  <= '0;
      length_q <= '0;
      len_lo_q <= '0;
      type_q   <= '0;
      gate0_q  <= '0;
      gate1_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      match_q  <= match_d;
      count_q  <= count_d;
      length_q <= length_d;
      len_lo_q <= len_lo_d;
      type_q   <= type_d;
      gate0_q  <= gate0_d;
      gate1_q  <= gate1_d;
    end
  end

endmodule

// File: hw/rtl/rrfp_queue.sv
// ----------------------------------------------------------------------------
// rrfp_queue: operation queue
// Small FIFO of field operations between the frame tracker and the back part.
// ----------------------------------------------------------------------------
module rrfp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rrfp_pkg::op_t push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output rrfp_pkg::op_t head_op_o
);

  rrfp_pkg::op_t               entry_q [rrfp_pkg::QUEUE_DEPTH];
  logic [rrfp_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [rrfp_pkg::QCNT_W-1:0] count_q;
  logic                        do_pop;

  assign full_o       = count_q == rrfp_pkg::QCNT_W'(rrfp_pkg::QUEUE_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_op_o    = entry_q[rptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == rrfp_pkg::QPTR_W'(rrfp_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == rrfp_pkg::QPTR_W'(rrfp_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/rrfp_back.sv
// ----------------------------------------------------------------------------
// rrfp_back: shadow, held values and result register
// Executes queued ops on the shadow copy, commits it, and issues results.
// ----------------------------------------------------------------------------
module rrfp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  rrfp_pkg::op_t   head_op_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      result_code_o,
  output logic [7:0]      report_type_o,
  output rrfp_pkg::report_t report_o
);

  rrfp_pkg::report_t pend_q, pend_d;
  rrfp_pkg::report_t held_q, held_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        code_q, code_d;
  logic [7:0]        type_q, type_d;
  rrfp_pkg::report_t res_q, res_d;

  logic emits;
  logic out_ready;
  logic exec;

  assign emits = (head_op_i.kind == rrfp_pkg::OP_ACCEPT)
              || (head_op_i.kind == rrfp_pkg::OP_ERR_FOOTER)
              || (head_op_i.kind == rrfp_pkg::OP_ERR_LEN);
  assign out_ready = !out_valid_q || !out_stall_i;
  assign exec      = head_valid_i && (!emits || out_ready);
  assign pop_o     = exec;

  always_comb begin
    pend_d      = pend_q;
    held_d      = held_q;
    code_d      = code_q;
    type_d      = type_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (exec) begin
      case (head_op_i.kind)
        rrfp_pkg::OP_LOAD: begin
          pend_d = held_q;
        end
        rrfp_pkg::OP_CAPTURE: begin
          unique case (head_op_i.field)
            rrfp_pkg::FLD_STATUS: pend_d.status       = head_op_i.data;
            rrfp_pkg::FLD_MD_LO:  pend_d.mdist[7:0]   = head_op_i.data;
            rrfp_pkg::FLD_MD_HI:  pend_d.mdist[15:8]  = head_op_i.data;
            rrfp_pkg::FLD_ME:     pend_d.menergy      = head_op_i.data;
            rrfp_pkg::FLD_SD_LO:  pend_d.sdist[7:0]   = head_op_i.data;
            rrfp_pkg::FLD_SD_HI:  pend_d.sdist[15:8]  = head_op_i.data;
            rrfp_pkg::FLD_SE:     pend_d.senergy      = head_op_i.data;
            rrfp_pkg::FLD_DD_LO:  pend_d.ddist[7:0]   = head_op_i.data;
            rrfp_pkg::FLD_DD_HI:  pend_d.ddist[15:8]  = head_op_i.data;
            rrfp_pkg::FLD_LIGHT:  pend_d.light        = head_op_i.data;
            rrfp_pkg::FLD_OUT:    pend_d.out          = head_op_i.data == rrfp_pkg::OUT_ON;
            default: ;
          endcase
        end
        rrfp_pkg::OP_ACCEPT: begin
          if (head_op_i.commit) begin
            held_d = pend_q;
          end
          out_valid_d = 1'b1;
          code_d      = rrfp_pkg::RES_OK;
          type_d      = head_op_i.data;
          res_d       = head_op_i.commit ? pend_q : held_q;
        end
        rrfp_pkg::OP_ERR_FOOTER: begin
          out_valid_d = 1'b1;
          code_d      = rrfp_pkg::RES_FOOTER_ERR;
          type_d      = '0;
          res_d       = '0;
        end
        rrfp_pkg::OP_ERR_LEN: begin
          out_valid_d = 1'b1;
          code_d      = rrfp_pkg::RES_LENGTH_ERR;
          type_d      = '0;
          res_d       = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    type_q <= type_d;
    res_q  <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_code_o = code_q;
  assign report_type_o = type_q;
  assign report_o      = res_q;

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: radar report frame parser testbench
// Sends framed and broken byte streams with random input gaps and output
// stalls; a local frame tracker predicts every result and each one is
// checked field by field as it leaves the parser.
// ----------------------------------------------------------------------------
module testbench;
  import rrfp_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 12;          // output register sits behind the op queue
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NO_BREAK     = -1;          // footer sent whole
  localparam int unsigned POS_TYPE = 0;      // first payload byte is the type

  // Marker sequences, first byte in the low lane.
  localparam logic [31:0] HDR_SEQ = {HDR_3, HDR_2, HDR_1, HDR_0};
  localparam logic [31:0] FTR_SEQ = {FTR_3, FTR_2, FTR_1, FTR_0};

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef struct packed {
    result_code_e code;
    logic [7:0]   rtype;
    report_t      rep;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_code_o;
  logic [7:0]  report_type_o;
  logic [7:0]  target_status_o;
  logic [15:0] move_dist_o;
  logic [7:0]  move_energy_o;
  logic [15:0] still_dist_o;
  logic [7:0]  still_energy_o;
  logic [15:0] detect_distance_o;
  logic [7:0]  light_level_o;
  logic        out_active_o;

  radar_report_frame_parser DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_code_o     (result_code_o),
    .report_type_o     (report_type_o),
    .target_status_o   (target_status_o),
    .move_dist_o       (move_dist_o),
    .move_energy_o     (move_energy_o),
    .still_dist_o      (still_dist_o),
    .still_energy_o    (still_energy_o),
    .detect_distance_o (detect_distance_o),
    .light_level_o     (light_level_o),
    .out_active_o      (out_active_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Frame tracker: mirrors the parser byte by byte
  // --------------------------------------------------------------------------
  phase_e       ph;
  logic [1:0]   mark_idx;      // header or footer bytes matched so far
  int unsigned  pos;           // payload byte position
  logic [15:0]  len_word;
  logic [7:0]   rtype;
  logic [7:0]   gate0, gate1;  // engineering gate counts
  report_t      shadow;        // values gathered from the current frame
  report_t      held;          // values of the last committed report

  frame_result_t frame_results_q[$];

  int  err_count  = 0;
  int  n_bytes    = 0;
  int  n_expected = 0;
  int  n_ok       = 0;
  int  n_ftr_err  = 0;
  int  n_len_err  = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  no_idle     = 1'b0;     // set for stretches without gaps or stalls

  function automatic void reset_tracker();
    ph        = PH_HUNT;
    mark_idx  = '0;
    pos       = 0;
    len_word  = '0;
    rtype     = '0;
    gate0     = '0;
    gate1     = '0;
    shadow    = '0;
    held      = '0;
  endfunction

  function automatic void push_result(input result_code_e code, input bit with_data);
    frame_result_t r;
    r      = '0;
    r.code = code;
    if (with_data) begin
      r.rtype = rtype;
      r.rep   = held;
    end
    frame_results_q.push_back(r);
    n_expected++;
  endfunction

  // Field capture for one payload byte.
  function automatic void capture_field(input int unsigned p, input logic [7:0] b);
    int unsigned light_at;
    case (p)
      POS_TYPE:   rtype = b;
      POS_STATUS: shadow.status = b;
      POS_MD_LO:  shadow.mdist[7:0] = b;
      POS_MD_HI:  shadow.mdist[15:8] = b;
      POS_ME:     shadow.menergy = b;
      POS_SD_LO:  shadow.sdist[7:0] = b;
      POS_SD_HI:  shadow.sdist[15:8] = b;
      POS_SE:     shadow.senergy = b;
      POS_DD_LO:  shadow.ddist[7:0] = b;
      POS_DD_HI:  shadow.ddist[15:8] = b;
      default: begin
        if (rtype == TYPE_ENG) begin
          // gate energies are skipped; light and OUT follow them
          light_at = POS_LIGHT0 + gate0 + gate1;
          if (p == POS_GATE0) gate0 = b;
          else if (p == POS_GATE1) gate1 = b;
          else if (p > POS_GATE1) begin
            if (p == light_at) shadow.light = b;
            else if (p == light_at + 1) shadow.out = (b == OUT_ON);
          end
        end
      end
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    case (ph)
      PH_LEN_LO: begin
        len_word = {8'h00, b};
        ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_word[15:8] = b;
        mark_idx = '0;
        if (len_word > MAX_PAYLOAD) begin
          // oversized: rejected, this byte is not reused for hunting
          ph = PH_HUNT;
          push_result(RES_LENGTH_ERR, 1'b0);
        end else begin
          // shadow starts from held values so short frames keep old fields
          shadow = held;
          pos    = 0;
          rtype  = '0;
          gate0  = '0;
          gate1  = '0;
          ph     = (len_word != 0) ? PH_PAYLOAD : PH_FOOTER;
        end
      end
      PH_PAYLOAD: begin
        capture_field(pos, b);
        pos++;
        if (pos >= len_word) begin
          ph = PH_FOOTER;
          mark_idx = '0;
        end
      end
      PH_FOOTER: begin
        if (b == FTR_SEQ[8*mark_idx +: 8]) begin
          if (mark_idx == 2'd3) begin
            if (rtype == TYPE_ENG || rtype == TYPE_BASIC) held = shadow;
            ph = PH_HUNT;
            mark_idx = '0;
            push_result(RES_OK, 1'b1);
          end else begin
            mark_idx++;
          end
        end else begin
          // wrong footer byte may itself start a new header
          ph = PH_HUNT;
          mark_idx = (b == HDR_0) ? 2'd1 : 2'd0;
          push_result(RES_FOOTER_ERR, 1'b0);
        end
      end
      default: begin
        ph = PH_HUNT;
        if (b == HDR_SEQ[8*mark_idx +: 8]) begin
          if (mark_idx == 2'd3) begin
            mark_idx = '0;
            ph = PH_LEN_LO;
          end else begin
            mark_idx++;
          end
        end else begin
          // sliding resync
          mark_idx = (b == HDR_0) ? 2'd1 : 2'd0;
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one item per call, entered and left at a rising edge
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int  gap;
    bit  taken;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    // stall is stable between edges, so look at it on the falling edge
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    parse_byte(b);
    n_bytes++;
  endtask

  // Header, length, payload and footer. Oversized lengths end after the
  // length bytes; brk picks a footer byte to corrupt.
  task automatic send_frame(input logic [7:0] typ, input logic [15:0] len,
                            input logic [7:0] g0, input logic [7:0] g1,
                            input int brk, input fill_e fill);
    logic [7:0]  b;
    int unsigned light_at;
    light_at = POS_LIGHT0 + g0 + g1;
    for (int i = 0; i < 4; i++) send_byte(HDR_SEQ[8*i +: 8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len > MAX_PAYLOAD) return;
    for (int unsigned p = 0; p < len; p++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      if (p == POS_TYPE) b = typ;
      else if (typ == TYPE_ENG && p == POS_GATE0) b = g0;
      else if (typ == TYPE_ENG && p == POS_GATE1) b = g1;
      else if (typ == TYPE_ENG && p == light_at + 1 &&
               (fill == FILL_ZERO || (fill == FILL_RANDOM && $urandom_range(0, 1) != 0)))
        b = OUT_ON;
      send_byte(b);
    end
    for (int i = 0; i < 4; i++) begin
      if (i == brk) begin
        b = ($urandom_range(0, 1) != 0) ? HDR_0 : 8'($urandom);
        if (b == FTR_SEQ[8*i +: 8]) b = ~b;
        send_byte(b);
        return;
      end
      send_byte(FTR_SEQ[8*i +: 8]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall bursts, results checked on the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, frame_results_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t MISMATCH %s: expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(negedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (frame_results_q.size() == 0) begin
        $display("%0t MISMATCH unexpected result: expected none, actual code %0d",
                 $time, result_code_o);
        err_count++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("result_code",     want.code,         result_code_o);
        check_field("report_type",     want.rtype,        report_type_o);
        check_field("target_status",   want.rep.status,   target_status_o);
        check_field("move_dist",       want.rep.mdist,    move_dist_o);
        check_field("move_energy",     want.rep.menergy,  move_energy_o);
        check_field("still_dist",      want.rep.sdist,    still_dist_o);
        check_field("still_energy",    want.rep.senergy,  still_energy_o);
        check_field("detect_distance", want.rep.ddist,    detect_distance_o);
        check_field("light_level",     want.rep.light,    light_level_o);
        check_field("out_active",      want.rep.out,      out_active_o);
        case (want.code)
          RES_OK:         n_ok++;
          RES_FOOTER_ERR: n_ftr_err++;
          default:        n_len_err++;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Broken header, repeated first byte, then an empty frame.
  task automatic test_header_resync();
    send_byte(HDR_0);
    send_byte(HDR_1);
    send_byte(HDR_2);
    send_byte(8'h00);
    send_byte(HDR_0);
    send_frame(8'h00, 16'h0000, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
  endtask

  // Just over the limit, high length byte set, all ones, and exactly at it.
  task automatic test_length_limit();
    send_frame(8'h00, 16'(MAX_PAYLOAD + 1), 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
    send_frame(8'h00, 16'h0100, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
    send_frame(8'h00, 16'hFFFF, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
    send_frame(TYPE_BASIC, 16'(MAX_PAYLOAD), 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
  endtask

  // First and last footer byte wrong; a wrong byte that is a header start.
  task automatic test_footer_errors();
    send_frame(TYPE_BASIC, 16'd13, 8'h00, 8'h00, 0, FILL_RANDOM);
    send_frame(TYPE_ENG, 16'd15, 8'h00, 8'h00, 3, FILL_RANDOM);
    // footer broken by a header start byte, the rest of the header follows
    for (int i = 0; i < 4; i++) send_byte(HDR_SEQ[8*i +: 8]);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(HDR_0);
    for (int i = 1; i < 4; i++) send_byte(HDR_SEQ[8*i +: 8]);
    send_byte(8'h00);
    send_byte(8'h00);
    for (int i = 0; i < 4; i++) send_byte(FTR_SEQ[8*i +: 8]);
  endtask

  // Basic and engineering reports at the extremes, then other types.
  task automatic test_report_types();
    send_frame(TYPE_BASIC, 16'd13, 8'h00, 8'h00, NO_BREAK, FILL_ONES);
    send_frame(TYPE_ENG, 16'd15, 8'h00, 8'h00, NO_BREAK, FILL_ZERO);
    send_frame(TYPE_ENG, 16'd20, 8'd2, 8'd3, NO_BREAK, FILL_ONES);
    send_frame(TYPE_ENG, 16'd20, 8'd2, 8'd3, NO_BREAK, FILL_RANDOM);
    send_frame(TYPE_ENG, 16'd20, 8'hFF, 8'hFF, NO_BREAK, FILL_RANDOM);
    send_frame(8'h00, 16'd13, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
    send_frame(8'hFF, 16'd20, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
    send_frame(8'h03, 16'd1, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
  endtask

  // Payload ends inside the fields: old values and old high bytes survive.
  task automatic test_short_payloads();
    send_frame(TYPE_BASIC, 16'd4, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
    send_frame(TYPE_BASIC, 16'd1, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
    send_frame(TYPE_BASIC, 16'd10, 8'h00, 8'h00, NO_BREAK, FILL_ZERO);
    send_frame(TYPE_ENG, 16'd14, 8'h00, 8'h00, NO_BREAK, FILL_ONES);
    send_frame(TYPE_ENG, 16'd12, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
  endtask

  // One random frame: mostly well formed, some oversized, some with a bad
  // footer, and now and then a short burst of line noise.
  task automatic send_random_frame();
    int          sel;
    int          k;
    int          brk;
    logic [7:0]  typ, g0, g1;
    logic [15:0] len;
    fill_e       fill;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      case ($urandom_range(0, 3))
        0:       len = 16'(MAX_PAYLOAD + 1);
        1:       len = 16'hFFFF;
        default: len = 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
      endcase
      send_frame(8'h00, len, 8'h00, 8'h00, NO_BREAK, FILL_RANDOM);
    end else if (sel < 15) begin
      repeat ($urandom_range(1, 8)) begin
        k = $urandom_range(0, 3);
        send_byte(($urandom_range(0, 2) == 0) ? HDR_SEQ[8*k +: 8] : 8'($urandom));
      end
    end else begin
      sel = $urandom_range(0, 99);
      typ = (sel < 50) ? TYPE_ENG : (sel < 85) ? TYPE_BASIC : 8'($urandom);
      g0  = 8'($urandom_range(0, 15));
      g1  = 8'($urandom_range(0, 15));
      if ($urandom_range(0, 4) == 0) begin
        g0 = 8'($urandom);
        g1 = 8'($urandom);
      end
      if (typ == TYPE_ENG && $urandom_range(0, 4) < 3 && g0 + g1 <= 30)
        len = 16'(POS_LIGHT0 + 2 + g0 + g1);
      else if ($urandom_range(0, 9) < 7)
        len = 16'($urandom_range(0, 20));
      else
        len = 16'($urandom_range(0, MAX_PAYLOAD));
      brk = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : NO_BREAK;
      sel = $urandom_range(0, 19);
      fill = (sel == 0) ? FILL_ZERO : (sel == 1) ? FILL_ONES : FILL_RANDOM;
      send_frame(typ, len, g0, g1, brk, fill);
    end
  endtask

  task automatic test_random_traffic();
    while (n_bytes < 1150 || n_expected < 50) begin
      // some frames run without any gaps or stalls
      no_idle = ($urandom_range(0, 5) == 0);
      send_random_frame();
    end
    no_idle = 1'b0;
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (8) send_random_frame();
  endtask

  initial begin
    reset_tracker();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_resync();
    test_length_limit();
    test_footer_errors();
    test_report_types();
    test_short_payloads();
    test_random_traffic();
    test_back_to_back();

    in_valid_i <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d accepted frames, %0d footer errors,",
             n_bytes, n_ok, n_ftr_err);
    $display("%0d oversized lengths, with %0d mismatching fields", n_len_err, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rrfp_pkg.sv
hw/rtl/rrfp_front.sv
hw/rtl/rrfp_queue.sv
hw/rtl/rrfp_back.sv
hw/rtl/radar_report_frame_parser.sv
test/testbench.sv
